@@ rtl/scf_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the sensor frame checker.
// No dependencies; every other file imports this package.
package scf_pkg;

  localparam int POS_W            = 5;
  localparam int QUEUE_DEPTH_DEF  = 2;
  localparam int ANGLE_BYTES      = 12;

  // byte positions within a frame
  localparam logic [POS_W-1:0] POS_PRE    = 5'd0;
  localparam logic [POS_W-1:0] POS_TYPE   = 5'd1;
  localparam logic [POS_W-1:0] POS_LEN_LO = 5'd2;
  localparam logic [POS_W-1:0] POS_LEN_HI = 5'd3;
  localparam logic [POS_W-1:0] POS_CRC_LO = 5'd4;
  localparam logic [POS_W-1:0] POS_CRC_HI = 5'd5;
  localparam logic [POS_W-1:0] POS_ID     = 5'd6;
  localparam logic [POS_W-1:0] POS_ANGLE0 = 5'd7;
  localparam logic [POS_W-1:0] POS_LAST   = 5'd18;

  localparam logic [7:0]  HDR_PRE    = 8'h5A;
  localparam logic [7:0]  HDR_TYPE   = 8'hA5;
  localparam logic [7:0]  HDR_LEN_LO = 8'h0D;
  localparam logic [7:0]  HDR_LEN_HI = 8'h00;
  localparam logic [7:0]  HDR_ID     = 8'hD9;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_TOP    = 16'h8000;
  localparam logic [15:0] CRC_INIT   = 16'h0000;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_HDR = 2'd1,
    ST_BAD_CRC = 2'd2
  } scf_status_t;

  // classified word handed from the front end to the back end
  typedef struct packed {
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
  } scf_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } scf_q_ctl_t;

  // CRC-16, poly 0x1021, MSB first, one byte per call
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/scf_if.sv @@
// Handshake channels of the sensor frame checker: byte input and frame result.
// Depends on scf_pkg.
interface scf_byte_if import scf_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface scf_result_if import scf_pkg::*; ();
  logic        valid;
  logic        ready;
  scf_status_t frame_status;
  logic [31:0] pitch_word;
  logic [31:0] roll_word;
  logic [31:0] yaw_word;

  modport source (output valid, output frame_status, output pitch_word, output roll_word,
                  output yaw_word, input ready);
  modport sink   (input valid, input frame_status, input pitch_word, input roll_word,
                  input yaw_word, output ready);
endinterface

@@ rtl/scf_front.sv @@
// Front end: accepts input words and tags each byte with its frame position.
// Depends on scf_pkg and scf_byte_if.
module scf_front import scf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  scf_byte_if.sink      in_ch,
  input  scf_q_ctl_t    q_ctl,
  output logic          push,
  output scf_entry_t    push_entry
);

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [POS_W-1:0] pos_cur;

  assign in_ch.ready = !q_ctl.full;
  assign push        = in_ch.valid && in_ch.ready;

  // frame_start drops any partial frame
  assign pos_cur          = in_ch.frame_start ? POS_PRE : pos_r;
  assign push_entry.data  = in_ch.data_byte;
  assign push_entry.pos   = pos_cur;

  always_comb begin
    pos_nxt = pos_r;
    if (push) begin
      pos_nxt = (pos_cur >= POS_LAST) ? POS_PRE : pos_cur + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_PRE;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

@@ rtl/scf_queue.sv @@
// Short FIFO of tagged bytes between the front and back ends.
// Depends on scf_pkg.
module scf_queue import scf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  scf_entry_t push_entry,
  input  logic       pop,
  output scf_entry_t pop_entry,
  output scf_q_ctl_t q_ctl
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  scf_entry_t       slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_ctl.full  = (cnt_r == CNT_FULL);
  assign q_ctl.empty = (cnt_r == '0);
  assign pop_entry   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ rtl/scf_back.sv @@
// Back end: CRC update, header checks, angle assembly and the result register.
// Depends on scf_pkg and scf_result_if.
module scf_back import scf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  scf_q_ctl_t    q_ctl,
  input  scf_entry_t    pop_entry,
  output logic          pop,
  scf_result_if.source  out_ch
);

  logic [15:0] crc_r, crc_nxt, crc_base;
  logic        hdr_good_r, hdr_good_nxt, hdr_base;
  logic [15:0] rcv_crc_r, rcv_crc_nxt;
  logic [7:0]  angle_r [ANGLE_BYTES];
  logic [3:0]  angle_idx;
  logic        is_last;
  logic        slot_free;

  logic        out_valid_r, out_valid_nxt;
  scf_status_t status_r, status_nxt;
  logic [31:0] pitch_r, roll_r, yaw_r;
  logic [31:0] pitch_nxt, roll_nxt, yaw_nxt;

  assign is_last   = (pop_entry.pos >= POS_LAST);
  assign slot_free = !out_valid_r || out_ch.ready;
  // the last byte needs the result register; any other byte goes straight through
  assign pop       = !q_ctl.empty && (!is_last || slot_free);
  assign angle_idx = 4'(pop_entry.pos - POS_ANGLE0);

  // byte 0 starts a fresh frame
  assign crc_base  = (pop_entry.pos == POS_PRE) ? CRC_INIT : crc_r;
  assign hdr_base  = (pop_entry.pos == POS_PRE) ? 1'b1 : hdr_good_r;

  always_comb begin
    crc_nxt      = crc_byte(crc_base, pop_entry.data);
    hdr_good_nxt = hdr_base;
    rcv_crc_nxt  = rcv_crc_r;
    case (pop_entry.pos)
      POS_PRE:    hdr_good_nxt = hdr_base && (pop_entry.data == HDR_PRE);
      POS_TYPE:   hdr_good_nxt = hdr_base && (pop_entry.data == HDR_TYPE);
      POS_LEN_LO: hdr_good_nxt = hdr_base && (pop_entry.data == HDR_LEN_LO);
      POS_LEN_HI: hdr_good_nxt = hdr_base && (pop_entry.data == HDR_LEN_HI);
      POS_CRC_LO: begin
        crc_nxt     = crc_base;
        rcv_crc_nxt = {rcv_crc_r[15:8], pop_entry.data};
      end
      POS_CRC_HI: begin
        crc_nxt     = crc_base;
        rcv_crc_nxt = {pop_entry.data, rcv_crc_r[7:0]};
      end
      POS_ID:     hdr_good_nxt = hdr_base && (pop_entry.data == HDR_ID);
      default:    ;
    endcase
  end

  always_comb begin
    status_nxt = ST_OK;
    if (!hdr_good_nxt) begin
      status_nxt = ST_BAD_HDR;
    end else if (crc_nxt != rcv_crc_r) begin
      status_nxt = ST_BAD_CRC;
    end
    pitch_nxt = {angle_r[3], angle_r[2], angle_r[1], angle_r[0]};
    roll_nxt  = {angle_r[7], angle_r[6], angle_r[5], angle_r[4]};
    yaw_nxt   = {pop_entry.data, angle_r[10], angle_r[9], angle_r[8]};
    if (status_nxt != ST_OK) begin
      pitch_nxt = '0;
      roll_nxt  = '0;
      yaw_nxt   = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop && is_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      hdr_good_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        crc_r      <= crc_nxt;
        hdr_good_r <= hdr_good_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rcv_crc_r <= rcv_crc_nxt;
      if (pop_entry.pos >= POS_ANGLE0 && !is_last) begin
        angle_r[angle_idx] <= pop_entry.data;
      end
    end
    if (pop && is_last) begin
      status_r <= status_nxt;
      pitch_r  <= pitch_nxt;
      roll_r   <= roll_nxt;
      yaw_r    <= yaw_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_status = status_r;
  assign out_ch.pitch_word   = pitch_r;
  assign out_ch.roll_word    = roll_r;
  assign out_ch.yaw_word     = yaw_r;

endmodule

@@ rtl/sensor_frame_crc_checker_top.sv @@
// Frame checker: up to one byte per cycle in, one status plus three angle words per frame out.
// Depends on scf_pkg, scf_if, scf_front, scf_queue and scf_back.
//
// Bytes of a 19-byte orientation frame enter one per cycle on in_ch while the queue has room;
// frame_start marks byte 0 and drops any partial frame, and after byte 18 the position wraps
// so the next byte opens a new frame. The front end tags each byte with its frame position and
// writes it into a short queue (QUEUE_DEPTH words); the back end takes one byte per cycle from
// the queue, except while a last byte waits for the result register, through a byte-wide CRC-16
// (poly 0x1021) update, which sets the rate of one byte per cycle. A result is registered when
// the last byte of a frame leaves the queue and is presented on out_ch from that register;
// status is ok, bad header (preamble, type, length or id) or bad CRC, and the angle words read
// zero on error. While a result waits, the back end keeps consuming bytes of the next frame and
// only stalls when that frame's last byte arrives before the pending result has been taken.
module sensor_frame_crc_checker_top import scf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  scf_byte_if.sink     in_ch,
  scf_result_if.source out_ch
);

  logic       push;
  logic       pop;
  scf_entry_t push_entry;
  scf_entry_t pop_entry;
  scf_q_ctl_t q_ctl;

  scf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_ctl      (q_ctl),
    .push       (push),
    .push_entry (push_entry)
  );

  scf_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_ctl      (q_ctl)
  );

  scf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_ctl     (q_ctl),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_ctl.full)
    else $error("byte written into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_ctl.empty)
    else $error("byte read from an empty queue");

  a_push_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !q_ctl.empty)
    else $error("queue empty right after a write without a read");

  a_result_from_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(pop && (pop_entry.pos == POS_LAST)))
    else $error("result raised without the last byte of a frame");

endmodule

@@ tb/scf_frame_checker.sv @@
// Scoreboard for the sensor frame checker: rebuilds each 19-byte frame from the accepted
// input words, predicts status and angle words, and compares every accepted result.
// Depends on scf_pkg and the scf_byte_if / scf_result_if channels.
module scf_frame_checker import scf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  scf_byte_if     in_mon,
  scf_result_if   out_mon,
  output int      fail_count,
  output int      frames_pending,
  output int      ok_frames,
  output int      hdr_frames,
  output int      crc_frames
);

  typedef struct {
    scf_status_t status;
    logic [31:0] pitch;
    logic [31:0] roll;
    logic [31:0] yaw;
  } frame_verdict_t;

  frame_verdict_t   verdict_q[$];

  logic [POS_W-1:0] next_pos;
  logic [15:0]      crc_acc;
  logic             hdr_ok;
  logic [15:0]      crc_rx;
  logic [31:0]      angle_acc [3];

  // bitwise form of the 0x1021 update, MSB first
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  task automatic restart_frame();
    next_pos     = '0;
    crc_acc      = CRC_INIT;
    hdr_ok       = 1'b1;
    crc_rx       = '0;
    angle_acc[0] = '0;
    angle_acc[1] = '0;
    angle_acc[2] = '0;
  endtask

  task automatic absorb_word(input logic [7:0] b, input logic start);
    logic [POS_W-1:0] p;
    int               idx;
    frame_verdict_t   v;
    if (start) restart_frame();
    p = (next_pos > POS_LAST) ? POS_LAST : next_pos;
    if (p != POS_CRC_LO && p != POS_CRC_HI) crc_acc = crc16_fold(crc_acc, b);
    case (p)
      POS_PRE:    if (b != HDR_PRE) hdr_ok = 1'b0;
      POS_TYPE:   if (b != HDR_TYPE) hdr_ok = 1'b0;
      POS_LEN_LO: if (b != HDR_LEN_LO) hdr_ok = 1'b0;
      POS_LEN_HI: if (b != HDR_LEN_HI) hdr_ok = 1'b0;
      POS_CRC_LO: crc_rx[7:0] = b;
      POS_CRC_HI: crc_rx[15:8] = b;
      POS_ID:     if (b != HDR_ID) hdr_ok = 1'b0;
      default: begin
        idx = int'(p) - int'(POS_ANGLE0);
        angle_acc[idx / 4][8 * (idx % 4) +: 8] = b;
      end
    endcase
    if (p < POS_LAST) begin
      next_pos = p + 1'b1;
    end else begin
      if (!hdr_ok) begin
        v.status = ST_BAD_HDR;
        hdr_frames++;
      end else if (crc_acc != crc_rx) begin
        v.status = ST_BAD_CRC;
        crc_frames++;
      end else begin
        v.status = ST_OK;
        ok_frames++;
      end
      v.pitch = (v.status == ST_OK) ? angle_acc[0] : '0;
      v.roll  = (v.status == ST_OK) ? angle_acc[1] : '0;
      v.yaw   = (v.status == ST_OK) ? angle_acc[2] : '0;
      verdict_q.push_back(v);
      restart_frame();
    end
  endtask

  task automatic compare_result();
    frame_verdict_t v;
    if (verdict_q.size() == 0) begin
      if (fail_count < 10)
        $display("unexpected result word: status %0d pitch %h roll %h yaw %h",
                 out_mon.frame_status, out_mon.pitch_word, out_mon.roll_word,
                 out_mon.yaw_word);
      fail_count++;
    end else begin
      v = verdict_q.pop_front();
      if (out_mon.frame_status !== v.status || out_mon.pitch_word !== v.pitch ||
          out_mon.roll_word !== v.roll || out_mon.yaw_word !== v.yaw) begin
        if (fail_count < 10)
          $display("result mismatch: exp status %0d pitch %h roll %h yaw %h / got %0d %h %h %h",
                   v.status, v.pitch, v.roll, v.yaw, out_mon.frame_status,
                   out_mon.pitch_word, out_mon.roll_word, out_mon.yaw_word);
        fail_count++;
      end
    end
  endtask

  initial begin
    fail_count     = 0;
    frames_pending = 0;
    ok_frames      = 0;
    hdr_frames     = 0;
    crc_frames     = 0;
    restart_frame();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_frame();
      verdict_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) absorb_word(in_mon.data_byte, in_mon.frame_start);
      if (out_mon.valid && out_mon.ready) compare_result();
    end
    frames_pending = verdict_q.size();
  end

endmodule

@@ tb/sensor_frame_crc_checker_top_tb.sv @@
// Stimulus and verdict for the sensor frame checker: directed frames, then random good,
// corrupted, truncated and noise traffic with random idling on both channels.
// Depends on scf_pkg, scf_if, the RTL top and scf_frame_checker.
module sensor_frame_crc_checker_top_tb;
  import scf_pkg::*;

  localparam int WORD_TARGET = 1950;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   words_sent = 0;
  bit   in_burst = 1'b0;
  bit   out_burst = 1'b0;
  int   chk_fails;
  int   frames_pending;
  int   ok_frames;
  int   hdr_frames;
  int   crc_frames;

  scf_byte_if   in_ch();
  scf_result_if out_ch();

  sensor_frame_crc_checker_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  scf_frame_checker frame_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .fail_count     (chk_fails),
    .frames_pending (frames_pending),
    .ok_frames      (ok_frames),
    .hdr_frames     (hdr_frames),
    .crc_frames     (crc_frames)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frames still expected", cycle_count,
               frames_pending);
      $display("sensor_frame_crc_checker_top_tb failed");
      $finish;
    end
  end

  // valid stays high across back-to-back words; only dropped when a gap is drawn
  task automatic send_word(input logic [7:0] b, input logic start);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.frame_start <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // bad_at < 0 keeps the header intact; cut sends only the first cut bytes
  task automatic send_frame(input logic [31:0] pitch, input logic [31:0] roll,
                            input logic [31:0] yaw, input int bad_at, input bit crc_flip,
                            input bit with_start, input int cut);
    logic [7:0]  fr [19];
    logic [15:0] crc;
    logic        fb;
    fr[POS_PRE]    = HDR_PRE;
    fr[POS_TYPE]   = HDR_TYPE;
    fr[POS_LEN_LO] = HDR_LEN_LO;
    fr[POS_LEN_HI] = HDR_LEN_HI;
    fr[POS_ID]     = HDR_ID;
    for (int i = 0; i < 4; i++) begin
      fr[POS_ANGLE0 + i]     = pitch[8 * i +: 8];
      fr[POS_ANGLE0 + 4 + i] = roll[8 * i +: 8];
      fr[POS_ANGLE0 + 8 + i] = yaw[8 * i +: 8];
    end
    if (bad_at >= 0) fr[bad_at] = fr[bad_at] ^ 8'($urandom_range(1, 255));
    crc = CRC_INIT;
    for (int i = 0; i < 19; i++) begin
      if (i != POS_CRC_LO && i != POS_CRC_HI) begin
        for (int j = 7; j >= 0; j--) begin
          fb  = crc[15] ^ fr[i][j];
          crc = {crc[14:0], 1'b0};
          if (fb) crc = crc ^ CRC_POLY;
        end
      end
    end
    if (crc_flip) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    fr[POS_CRC_LO] = crc[7:0];
    fr[POS_CRC_HI] = crc[15:8];
    for (int i = 0; i < cut; i++) send_word(fr[i], with_start && i == 0);
  endtask

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // result side: random stalls per word, with stretches of none
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    int sel;
    int hdr_slot;
    int noise_len;
    logic [POS_W-1:0] hdr_pos [5];
    hdr_pos = '{POS_PRE, POS_TYPE, POS_LEN_LO, POS_LEN_HI, POS_ID};
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= '0;
    in_ch.frame_start <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // partial frame dropped by the next start, then a good frame with extreme angles
    send_frame($urandom(), $urandom(), $urandom(), -1, 1'b0, 1'b1, 4);
    send_frame(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0001, -1, 1'b0, 1'b1, 19);

    while (words_sent < WORD_TARGET) begin
      if ($urandom_range(0, 7) == 0) in_burst = !in_burst;
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        send_frame(pick_angle(), pick_angle(), pick_angle(), -1, 1'b0,
                   $urandom_range(0, 7) != 0, 19);
      end else if (sel < 65) begin
        send_frame(pick_angle(), pick_angle(), pick_angle(), -1, 1'b1, 1'b1, 19);
      end else if (sel < 80) begin
        // header damage, sometimes with a bad CRC as well
        hdr_slot = $urandom_range(0, 4);
        send_frame(pick_angle(), pick_angle(), pick_angle(), hdr_pos[hdr_slot],
                   $urandom_range(0, 1), 1'b1, 19);
      end else if (sel < 90) begin
        send_frame(pick_angle(), pick_angle(), pick_angle(), -1, 1'b0, 1'b1,
                   $urandom_range(1, 18));
      end else begin
        noise_len = $urandom_range(1, 30);
        for (int i = 0; i < noise_len; i++)
          send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d input words and %0d frames: %0d ok, %0d bad header, %0d bad crc",
             words_sent, ok_frames + hdr_frames + crc_frames, ok_frames, hdr_frames,
             crc_frames);
    if (frames_pending != 0) $display("%0d expected frames never arrived", frames_pending);
    if (chk_fails == 0 && frames_pending == 0) begin
      $display("sensor_frame_crc_checker_top_tb passed");
    end else begin
      $display("sensor_frame_crc_checker_top_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/scf_pkg.sv
rtl/scf_if.sv
rtl/scf_front.sv
rtl/scf_queue.sv
rtl/scf_back.sv
rtl/sensor_frame_crc_checker_top.sv
tb/scf_frame_checker.sv
tb/sensor_frame_crc_checker_top_tb.sv
